[hdl/ocvsoc_pkg.sv]
// ----------------------------------------------------------------------------
// ocvsoc_pkg
// Shared types, constants and the open-circuit-voltage table for the
// state-of-charge lookup.
// ----------------------------------------------------------------------------
package ocvsoc_pkg;

    localparam int ENTRY_W  = 13;   // widest table voltage is 4190 mV
    localparam int IDX_W    = 8;    // scan index covers up to 256 entries
    localparam int VOLT_W   = 16;
    localparam int SOC_W    = 10;
    localparam int ALU_W    = 17;   // holds (v - lo) * 10
    localparam int QUO_W    = 4;    // fraction is 0..9
    localparam int ROM_LEN  = 101;
    localparam int ROM_AW   = 7;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [SOC_W-1:0]   soc_t;
    typedef logic [ALU_W-1:0]   alu_t;

    localparam soc_t   FULL_PERMILLE = 10'd1000;
    localparam soc_t   EMPTY_PERMILLE = 10'd0;
    localparam idx_t   TOP_PERCENT   = 8'd100;
    localparam entry_t EMPTY_MV      = 13'd3200;

    // Open-circuit voltage per percent, 100 % first.
    localparam entry_t OCV_ROM [ROM_LEN] = '{
        13'd4190, 13'd4174, 13'd4162, 13'd4152, 13'd4142,
        13'd4132, 13'd4123, 13'd4113, 13'd4104, 13'd4094,
        13'd4086, 13'd4079, 13'd4074, 13'd4069, 13'd4062,
        13'd4050, 13'd4031, 13'd4013, 13'd3999, 13'd3988,
        13'd3979, 13'd3972, 13'd3966, 13'd3961, 13'd3957,
        13'd3953, 13'd3949, 13'd3943, 13'd3938, 13'd3931,
        13'd3925, 13'd3918, 13'd3912, 13'd3905, 13'd3898,
        13'd3891, 13'd3884, 13'd3876, 13'd3869, 13'd3861,
        13'd3854, 13'd3847, 13'd3841, 13'd3835, 13'd3830,
        13'd3826, 13'd3821, 13'd3817, 13'd3812, 13'd3809,
        13'd3806, 13'd3802, 13'd3799, 13'd3796, 13'd3793,
        13'd3790, 13'd3787, 13'd3785, 13'd3783, 13'd3781,
        13'd3778, 13'd3776, 13'd3774, 13'd3772, 13'd3770,
        13'd3768, 13'd3767, 13'd3765, 13'd3764, 13'd3762,
        13'd3760, 13'd3758, 13'd3756, 13'd3754, 13'd3751,
        13'd3748, 13'd3744, 13'd3741, 13'd3738, 13'd3735,
        13'd3731, 13'd3727, 13'd3721, 13'd3715, 13'd3710,
        13'd3705, 13'd3699, 13'd3691, 13'd3686, 13'd3684,
        13'd3683, 13'd3681, 13'd3679, 13'd3675, 13'd3666,
        13'd3636, 13'd3591, 13'd3532, 13'd3454, 13'd3335,
        13'd3200
    };

    // Entries past the stored table read as the empty voltage.
    function automatic entry_t ocv_entry(input idx_t idx);
        entry_t val;
        val = EMPTY_MV;
        if (idx < IDX_W'(ROM_LEN))
        begin
            val = OCV_ROM[idx[ROM_AW-1:0]];
        end
        return val;
    endfunction

endpackage

[hdl/ocv_soc_table_interpolator_top.sv]
// ----------------------------------------------------------------------------
// ocv_soc_table_interpolator_top
// Cell voltage to state of charge by table scan and linear interpolation.
// ----------------------------------------------------------------------------
//
//  channel   ports                      handshake
//  --------  -------------------------  ---------------------------------
//  input     cell_voltage_mv[15:0]      beat taken when start && !busy
//  result    charge_permille[9:0]       one-cycle beat marked by done
//
//  Sequence: a voltage at or above full or at or below empty is settled by
//  the full and empty compares alone. Otherwise the scan stops at table
//  index i (at most 100 for the 101-entry table), then span, difference,
//  the 4-step restoring divide and the final sum follow. The scan takes one
//  entry per cycle; scan and divide both run on the one shared subtractor.
//  busy is high from the cycle after the input beat until done rises;
//  a new start is taken in the cycle done is shown.
//  Reset (rst_n low, asynchronous) returns the sequencer to idle and
//  drops done. The receiver cannot stall: each result is shown once.
//
module ocv_soc_table_interpolator_top
    import ocvsoc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 101   // entries used by the scan, 2..256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [VOLT_W-1:0]   cell_voltage_mv,
    output logic                done,
    output logic [SOC_W-1:0]    charge_permille
);

    // The last used entry is the empty point.
    localparam idx_t LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FULL  = 3'd1;  // v >= first entry ?
    localparam logic [2:0] S_EMPTY = 3'd2;  // last entry >= v ?
    localparam logic [2:0] S_SCAN  = 3'd3;  // walk down until entry <= v
    localparam logic [2:0] S_SPAN  = 3'd4;  // hi - lo
    localparam logic [2:0] S_DIFF  = 3'd5;  // (v - lo) * 10
    localparam logic [2:0] S_DIV   = 3'd6;  // one quotient bit per cycle
    localparam logic [2:0] S_FINAL = 3'd7;  // percent * 10 + fraction

    logic [2:0]          state_reg, state_next;
    logic [VOLT_W-1:0]   volt_reg, volt_next;
    idx_t                idx_reg, idx_next;
    entry_t              span_reg, span_next;
    alu_t                rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [1:0]          bit_reg, bit_next;
    logic                done_reg, done_next;
    soc_t                soc_reg, soc_next;

    // Shared subtractor: the voltage compares, differences and divide steps run here.
    alu_t                alu_a, alu_b;
    logic [ALU_W:0]      alu_diff;
    logic                alu_ge;

    entry_t              rom_cur, rom_prev;
    alu_t                diff_x10;
    idx_t                pct;
    soc_t                pct_x10;

    assign rom_cur  = ocv_entry(idx_reg);
    assign rom_prev = ocv_entry(idx_reg - 1'b1);

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = ~alu_diff[ALU_W];

    // (v - lo) * 10 as two shifted adds; v - lo is below the span, so 13 bits.
    assign diff_x10 = {alu_diff[ALU_W-4:0], 3'b000} + {alu_diff[ALU_W-2:0], 1'b0};

    // With 101 entries the scan stops at index 1..100; a higher index gives zero.
    // So the percent term is 0..99 and the result stays at or below 999.
    assign pct     = (idx_reg <= TOP_PERCENT) ? (TOP_PERCENT - idx_reg) : '0;
    assign pct_x10 = {pct[6:0], 3'b000} + {2'b00, pct[6:0], 1'b0};

    // Operand select for the shared subtractor
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        case (state_reg)
            S_FULL:
            begin
                alu_a = ALU_W'(volt_reg);
                alu_b = ALU_W'(ocv_entry('0));
            end
            S_EMPTY:
            begin
                alu_a = ALU_W'(ocv_entry(LAST_IDX));
                alu_b = ALU_W'(volt_reg);
            end
            S_SCAN, S_DIFF:
            begin
                alu_a = ALU_W'(volt_reg);
                alu_b = ALU_W'(rom_cur);
            end
            S_SPAN:
            begin
                alu_a = ALU_W'(rom_prev);
                alu_b = ALU_W'(rom_cur);
            end
            S_DIV:
            begin
                alu_a = rem_reg;
                alu_b = ALU_W'(span_reg) << bit_reg;
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        volt_next  = volt_reg;
        idx_next   = idx_reg;
        span_next  = span_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        soc_next   = soc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    volt_next  = cell_voltage_mv;
                    state_next = S_FULL;
                end
            end
            S_FULL:
            begin
                if (alu_ge)
                begin
                    soc_next   = FULL_PERMILLE;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMPTY;
                end
            end
            S_EMPTY:
            begin
                if (alu_ge)
                begin
                    soc_next   = EMPTY_PERMILLE;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_t'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Advance while the entry is still above the voltage.
                if ((idx_reg < LAST_IDX) && !alu_ge)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                span_next = alu_diff[ENTRY_W-1:0];
                quo_next  = '0;
                // Zero or negative span gives a zero fraction.
                if (!alu_ge || (alu_diff[ALU_W-1:0] == '0))
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                rem_next   = diff_x10;
                bit_next   = 2'd3;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (alu_ge)
                begin
                    rem_next = alu_diff[ALU_W-1:0];
                end
                quo_next = {quo_reg[QUO_W-2:0], alu_ge};
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 2'd0)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                soc_next   = pct_x10 + SOC_W'(quo_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge clk)
    begin
        volt_reg <= volt_next;
        idx_reg  <= idx_next;
        span_reg <= span_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        bit_reg  <= bit_next;
        soc_reg  <= soc_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign charge_permille = soc_reg;

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while sequencer busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("input beat did not start the sequencer");

    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (charge_permille <= FULL_PERMILLE))
        else $error("state of charge out of range");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((idx_reg != '0) && (idx_reg <= LAST_IDX)))
        else $error("scan index outside the table");

    a_div_quo: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL) |-> (quo_reg <= 4'd9))
        else $error("interpolation fraction above nine");

endmodule
